// ===== rtl/tdn_pkg.sv =====
// ----------------------------------------------------------------------------
// tdn_pkg
// shared types and constants of the tf-idf document norm block
// ----------------------------------------------------------------------------
`default_nettype none

package tdn_pkg;

  localparam int unsigned DocSlots    = 4096;
  localparam int unsigned LogFracBits = 24;
  localparam logic [31:0] Ln2Q32      = 32'd2977044472;

  typedef struct packed {
    logic [15:0] peak;
    logic [63:0] sum;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/tdn_store.sv =====
// ----------------------------------------------------------------------------
// tdn_store
// per-document store of peak frequency and weight sum, one write and one
// registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tdn_store #(
  parameter int unsigned Depth = tdn_pkg::DocSlots,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [Aw-1:0]   wr_addr_i,
  input  wire tdn_pkg::entry_t wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [Aw-1:0]   rd_addr_i,
  output tdn_pkg::entry_t      rd_data_o
);

  tdn_pkg::entry_t mem_q [Depth];
  tdn_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ===== rtl/tfidf_document_norm.sv =====
// ----------------------------------------------------------------------------
// tfidf_document_norm
// per-document tf-idf vector norm with a shared multiplier and sequencer
// ----------------------------------------------------------------------------
// After reset the block sweeps its document store to zero, one slot per cycle,
// and takes no item until the sweep ends. Items are then handled one at a
// time through a single 32x32 multiplier and a one-bit-per-cycle root and
// divide unit. A posting with nonzero idf runs two logarithms of 5 normalize
// steps and 24 squarings each, then idf, weight, square and update; with zero
// idf only weight, square and update. A read runs 32 root steps, then 32
// divide steps; an unseen or out-of-range read skips both. A finished result
// waits in the output register while the next item is taken.
`default_nettype none

module tfidf_document_norm #(
  parameter int unsigned DOC_SLOTS = tdn_pkg::DocSlots
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [11:0] doc_index_i,
  input  wire logic [15:0] term_freq_i,
  input  wire logic [31:0] term_docs_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      norm_o,
  output logic [15:0]      peak_freq_o,
  output logic             unseen_o
);

  localparam int unsigned Aw = $clog2(DOC_SLOTS);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_NORM  = 4'd3;
  localparam logic [3:0] ST_SQR   = 4'd4;
  localparam logic [3:0] ST_IDF   = 4'd5;
  localparam logic [3:0] ST_WGT   = 4'd6;
  localparam logic [3:0] ST_SQ    = 4'd7;
  localparam logic [3:0] ST_ACC   = 4'd8;
  localparam logic [3:0] ST_ROOT  = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [Aw-1:0] clr_q, clr_d;
  logic [31:0] num_docs_q;

  logic        func_q, func_d;
  logic        slot_ok_q, slot_ok_d;
  logic [Aw-1:0] addr_q, addr_d;
  logic [15:0] freq_q, freq_d;
  logic [31:0] docs_q, docs_d;
  logic        zero_idf_q, zero_idf_d;

  logic [31:0] x_q, x_d;
  logic [4:0]  top_q, top_d;
  logic [31:0] m_q, m_d;
  logic [28:0] res_q, res_d;
  logic [28:0] la_q, la_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        pass_q, pass_d;
  logic [31:0] op_q, op_d;
  logic [63:0] sq_q, sq_d;

  logic [63:0] rem_q, rem_d;
  logic [63:0] root_q, root_d;
  logic [63:0] bit_q, bit_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dr_q, dr_d;
  logic [15:0] pk_q, pk_d;
  logic        uns_q, uns_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] norm_q, norm_d;
  logic [15:0] peak_q, peak_d;
  logic        unseen_q, unseen_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [32:0] sqr_p;
  logic [28:0] res_new;
  logic [4:0]  sh;
  logic [31:0] hi;
  logic [63:0] root_t;
  logic [16:0] div_t;
  logic [64:0] acc_s;
  logic        in_xfer;

  logic            wr_en;
  logic [Aw-1:0]   wr_addr;
  tdn_pkg::entry_t wr_data;
  tdn_pkg::entry_t rd_data;

  tdn_store #(
    .Depth (DOC_SLOTS),
    .Aw    (Aw)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (in_xfer),
    .rd_addr_i (Aw'(doc_index_i)),
    .rd_data_o (rd_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQR: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      ST_IDF: begin
        mul_a = op_q;
        mul_b = tdn_pkg::Ln2Q32;
      end
      ST_WGT: begin
        mul_a = {16'd0, freq_q};
        mul_b = op_q;
      end
      ST_SQ: begin
        mul_a = op_q;
        mul_b = op_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign sqr_p = prod[63:31];

  always_comb begin
    unique case (cnt_q)
      5'd0:    sh = 5'd16;
      5'd1:    sh = 5'd8;
      5'd2:    sh = 5'd4;
      5'd3:    sh = 5'd2;
      default: sh = 5'd1;
    endcase
  end

  assign hi      = x_q >> (6'd32 - {1'b0, sh});
  assign res_new = sqr_p[32] ? (res_q | (29'd1 << cnt_q)) : res_q;
  assign root_t  = root_q + bit_q;
  assign div_t   = {dr_q, quo_q[31]};
  assign acc_s   = {1'b0, rd_data.sum} + {1'b0, sq_q};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    slot_ok_d   = slot_ok_q;
    addr_d      = addr_q;
    freq_d      = freq_q;
    docs_d      = docs_q;
    zero_idf_d  = zero_idf_q;
    x_d         = x_q;
    top_d       = top_q;
    m_d         = m_q;
    res_d       = res_q;
    la_d        = la_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    op_d        = op_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    root_d      = root_q;
    bit_d       = bit_q;
    quo_d       = quo_q;
    dr_d        = dr_q;
    pk_d        = pk_q;
    uns_d       = uns_q;
    out_valid_d = out_valid_q && !out_ready_i;
    norm_d      = norm_q;
    peak_d      = peak_q;
    unseen_d    = unseen_q;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == Aw'(DOC_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          func_d     = func_i;
          slot_ok_d  = {20'd0, doc_index_i} < 32'(DOC_SLOTS);
          addr_d     = Aw'(doc_index_i);
          freq_d     = term_freq_i;
          docs_d     = term_docs_i;
          zero_idf_d = (term_docs_i == 32'd0) || (term_docs_i >= num_docs_q);
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!func_q) begin
          if (!slot_ok_q) begin
            state_d = ST_IDLE;
          end else if (zero_idf_q) begin
            op_d    = '0;
            state_d = ST_WGT;
          end else begin
            x_d     = num_docs_q;
            top_d   = 5'd31;
            cnt_d   = '0;
            pass_d  = 1'b0;
            state_d = ST_NORM;
          end
        end else if (!slot_ok_q || rd_data.peak == 16'd0) begin
          quo_d   = '0;
          pk_d    = '0;
          uns_d   = 1'b1;
          state_d = ST_OUT;
        end else begin
          rem_d   = rd_data.sum;
          root_d  = '0;
          bit_d   = 64'd1 << 62;
          cnt_d   = 5'd31;
          pk_d    = rd_data.peak;
          uns_d   = 1'b0;
          state_d = ST_ROOT;
        end
      end
      ST_NORM: begin
        if (hi == 32'd0) begin
          x_d   = x_q << sh;
          top_d = top_q - sh;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd4) begin
          m_d     = (hi == 32'd0) ? (x_q << sh) : x_q;
          res_d   = {((hi == 32'd0) ? (top_q - sh) : top_q), 24'd0};
          cnt_d   = 5'(tdn_pkg::LogFracBits - 1);
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        m_d   = sqr_p[32] ? sqr_p[32:1] : sqr_p[31:0];
        res_d = res_new;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 5'd0) begin
          if (!pass_q) begin
            la_d    = res_new;
            x_d     = docs_q;
            top_d   = 5'd31;
            cnt_d   = '0;
            pass_d  = 1'b1;
            state_d = ST_NORM;
          end else begin
            op_d    = {3'd0, la_q} - {3'd0, res_new};
            state_d = ST_IDF;
          end
        end
      end
      ST_IDF: begin
        op_d    = {8'd0, prod[63:40]};
        state_d = ST_WGT;
      end
      ST_WGT: begin
        op_d    = prod[39:8];
        state_d = ST_SQ;
      end
      ST_SQ: begin
        sq_d    = prod;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        wr_en        = 1'b1;
        wr_data.peak = (freq_q > rd_data.peak) ? freq_q : rd_data.peak;
        wr_data.sum  = acc_s[64] ? '1 : acc_s[63:0];
        state_d      = ST_IDLE;
      end
      ST_ROOT: begin
        if (rem_q >= root_t) begin
          rem_d  = rem_q - root_t;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 5'd0) begin
          quo_d   = (rem_q >= root_t) ? 32'((root_q >> 1) + bit_q) : 32'(root_q >> 1);
          dr_d    = '0;
          cnt_d   = 5'd31;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_t >= {1'b0, pk_q}) begin
          dr_d  = 16'(div_t - {1'b0, pk_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          dr_d  = div_t[15:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 5'd0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          norm_d      = quo_q;
          peak_d      = pk_q;
          unseen_d    = uns_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      num_docs_q  <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_docs_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    slot_ok_q  <= slot_ok_d;
    addr_q     <= addr_d;
    freq_q     <= freq_d;
    docs_q     <= docs_d;
    zero_idf_q <= zero_idf_d;
    x_q        <= x_d;
    top_q      <= top_d;
    m_q        <= m_d;
    res_q      <= res_d;
    la_q       <= la_d;
    cnt_q      <= cnt_d;
    pass_q     <= pass_d;
    op_q       <= op_d;
    sq_q       <= sq_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    bit_q      <= bit_d;
    quo_q      <= quo_d;
    dr_q       <= dr_d;
    pk_q       <= pk_d;
    uns_q      <= uns_d;
    norm_q     <= norm_d;
    peak_q     <= peak_d;
    unseen_q   <= unseen_d;
  end

  assign out_valid_o = out_valid_q;
  assign norm_o      = norm_q;
  assign peak_freq_o = peak_q;
  assign unseen_o    = unseen_q;

  a_wr_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_ACC || state_q == ST_CLEAR))
    else $error("store written outside update or sweep");

  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result appeared without a finished read");

  a_unseen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unseen_o) |-> (norm_o == 32'd0 && peak_freq_o == 16'd0))
    else $error("unseen result carries data");

  a_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_LOAD)
    else $error("transfer not followed by store read");

endmodule

`default_nettype wire

// ===== sim/tdn_checker.sv =====
// ----------------------------------------------------------------------------
// tdn_checker
// watches the posting and result channels of the tf-idf document norm block,
// keeps its own per-document sums and peaks and compares every read result
// ----------------------------------------------------------------------------
module tdn_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [11:0] doc_index_i,
  input  logic [15:0] term_freq_i,
  input  logic [31:0] term_docs_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] norm_i,
  input  logic [15:0] peak_freq_i,
  input  logic        unseen_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] norm;
    logic [15:0] peak;
    logic        unseen;
  } doc_norm_t;

  logic [63:0] weight_sum[tdn_pkg::DocSlots];
  logic [15:0] peak_freq[tdn_pkg::DocSlots];
  logic [31:0] doc_count;
  doc_norm_t   norm_q[$];

  function automatic logic [31:0] log2_fixed(logic [31:0] x);
    int          top;
    logic [63:0] m;
    logic [31:0] res;
    top = 31;
    while (top > 0 && !x[top]) top--;
    m   = 64'(x) << (31 - top);
    res = 32'(top) << tdn_pkg::LogFracBits;
    for (int i = tdn_pkg::LogFracBits - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m      = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] idf_fixed(logic [31:0] docs);
    logic [63:0] diff;
    if (docs == 0 || docs >= doc_count) return 32'd0;
    diff = 64'(log2_fixed(doc_count) - log2_fixed(docs));
    return 32'((diff * 64'(tdn_pkg::Ln2Q32)) >> 40);
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] rem, root, bit_q;
    rem   = x;
    root  = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > x) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (rem >= root + bit_q) begin
        rem  = rem - (root + bit_q);
        root = (root >> 1) + bit_q;
      end else begin
        root = root >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return root;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  assign pending_o = norm_q.size();

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] w, sq, s;
    doc_norm_t   exp_r;
    if (!rst_ni) begin
      doc_count = 32'd1;
      for (int i = 0; i < tdn_pkg::DocSlots; i++) begin
        weight_sum[i] = 0;
        peak_freq[i]  = 0;
      end
      norm_q.delete();
    end else begin
      if (cfg_we_i) doc_count = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (norm_q.size() == 0) begin
          $display("unexpected result transfer at %0t", $realtime);
          errors_o++;
        end else begin
          exp_r = norm_q.pop_front();
          if (norm_i !== exp_r.norm) report_mismatch("norm", norm_i, exp_r.norm);
          if (peak_freq_i !== exp_r.peak) report_mismatch("peak_freq", peak_freq_i, exp_r.peak);
          if (unseen_i !== exp_r.unseen) report_mismatch("unseen", unseen_i, exp_r.unseen);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (!func_i) begin
          if (term_freq_i > peak_freq[doc_index_i]) peak_freq[doc_index_i] = term_freq_i;
          w  = (64'(term_freq_i) * 64'(idf_fixed(term_docs_i))) >> 8;
          sq = w * w;
          s  = weight_sum[doc_index_i] + sq;
          if (s < sq) s = '1;
          weight_sum[doc_index_i] = s;
        end else if (peak_freq[doc_index_i] == 0) begin
          norm_q.push_back('{norm: 32'd0, peak: 16'd0, unseen: 1'b1});
        end else begin
          exp_r.norm   = 32'(int_root(weight_sum[doc_index_i]) / 64'(peak_freq[doc_index_i]));
          exp_r.peak   = peak_freq[doc_index_i];
          exp_r.unseen = 1'b0;
          norm_q.push_back(exp_r);
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives postings and reads into the tf-idf document norm block over several
// document counts, with random idling on both channels; verdict from checker
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FuncAccum = 1'b0;
  localparam logic FuncRead  = 1'b1;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [31:0] cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic        func_i = 0;
  logic [11:0] doc_index_i = 0;
  logic [15:0] term_freq_i = 0;
  logic [31:0] term_docs_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [31:0] norm_o;
  logic [15:0] peak_freq_o;
  logic        unseen_o;
  int          errors, pending;
  bit          quiet = 0;

  tfidf_document_norm u_top (.*);

  tdn_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .doc_index_i, .term_freq_i,
    .term_docs_i, .out_valid_i(out_valid_o), .out_ready_i, .norm_i(norm_o),
    .peak_freq_i(peak_freq_o), .unseen_i(unseen_o), .errors_o(errors),
    .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        n = $urandom_range(1, 7);
      end else begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 7);
      end
      repeat (n - 1) @(negedge clk_i);
    end
  end

  task automatic send_item(logic f, logic [11:0] d, logic [15:0] fr, logic [31:0] td);
    int gap;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    doc_index_i <= d;
    term_freq_i <= fr;
    term_docs_i <= td;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic set_doc_count(logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(int n, logic [31:0] docs);
    logic [11:0] d;
    logic [31:0] td;
    for (int i = 0; i < n; i++) begin
      d = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
      case ($urandom_range(0, 5))
        0: td = $urandom;
        1: td = 0;
        2: td = docs;
        default: td = (docs > 1) ? $urandom_range(1, docs - 1) : $urandom;
      endcase
      if ($urandom_range(0, 9) < 7)
        send_item(FuncAccum, d, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom), td);
      else
        send_item(FuncRead, d, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // default count of one: every idf is zero
    send_item(FuncRead, 12'd0, 16'd0, 32'd0);
    send_item(FuncAccum, 12'd5, 16'hffff, 32'd0);
    send_item(FuncRead, 12'd5, 16'd0, 32'd0);
    send_item(FuncAccum, 12'd6, 16'd0, 32'd0);
    send_item(FuncRead, 12'd6, 16'd0, 32'd0);

    set_doc_count(32'hffff_ffff);
    send_item(FuncAccum, 12'hfff, 16'hffff, 32'd1);
    send_item(FuncAccum, 12'hfff, 16'hffff, 32'd1);
    send_item(FuncAccum, 12'hfff, 16'd1, 32'hffff_fffe);
    send_item(FuncAccum, 12'hfff, 16'd7, 32'hffff_ffff);
    send_item(FuncRead, 12'hfff, 16'hffff, 32'hffff_ffff);
    send_item(FuncAccum, 12'd1, 16'd1, 32'd1);
    send_item(FuncAccum, 12'd1, 16'd3, 32'd0);
    send_item(FuncRead, 12'd1, 16'd0, 32'd0);
    send_item(FuncAccum, 12'd2, 16'd0, 32'd1);
    send_item(FuncRead, 12'd2, 16'd0, 32'd0);

    set_doc_count(32'd0);
    send_item(FuncAccum, 12'd3, 16'd9, 32'd1);
    send_item(FuncRead, 12'd3, 16'd0, 32'd0);

    set_doc_count(32'd1000);
    send_item(FuncAccum, 12'd4, 16'd100, 32'd999);
    send_item(FuncAccum, 12'd4, 16'd50, 32'd3);
    send_item(FuncRead, 12'd4, 16'd0, 32'd0);
    random_phase(250, 32'd1000);
    drain();
    random_phase(150, 32'd1000);

    set_doc_count(32'hffff_ffff);
    random_phase(400, 32'hffff_ffff);

    set_doc_count(32'd2);
    random_phase(150, 32'd2);

    set_doc_count($urandom | 32'd1);
    random_phase(250, 32'h7fff_ffff);

    set_doc_count(32'd50);
    quiet = 1;
    random_phase(300, 32'd50);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tdn_pkg.sv
rtl/tdn_store.sv
rtl/tfidf_document_norm.sv
sim/tdn_checker.sv
sim/tb_top.sv
